// ===== rtl/pwm_input_capture_measure_defines.svh =====
// Assertion macros used by the checker file
`ifndef PWM_INPUT_CAPTURE_MEASURE_DEFINES_SVH
`define PWM_INPUT_CAPTURE_MEASURE_DEFINES_SVH

// Clocked assertion, muted while reset is held
`define PIMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define PIMM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/pimm_pkg.sv =====
package pimm_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } pimm_state_t;

    // Per-channel capture phase
    typedef logic [1:0] pimm_phase_t;
    localparam pimm_phase_t PH_RISE1 = 2'd0;
    localparam pimm_phase_t PH_FALL  = 2'd1;
    localparam pimm_phase_t PH_RISE2 = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  REG_COEF_LEFT  = 2'd0;
    localparam logic [1:0]  REG_COEF_RIGHT = 2'd1;

    // Field widths
    localparam int CAP_W   = 16;
    localparam int COEF_W  = 16;
    localparam int TICKS_W = 16;
    localparam int PER_W   = 17;
    localparam int FREQ_W  = 20;
    localparam int SPEED_W = 28;
    localparam int PROD_W  = FREQ_W + COEF_W;
    localparam int Q_FRAC  = 8;

    // 1 MHz timer tick
    localparam logic [FREQ_W-1:0] TICK_HZ   = 20'd1000000;
    localparam logic [COEF_W-1:0] COEF_RST  = 16'd256;
    localparam int                DIV_STEPS = FREQ_W;
    localparam int                DCNT_W    = $clog2(DIV_STEPS);

endpackage

// ===== rtl/pwm_input_capture_measure.sv =====
// An edge that opens or splits a measurement is absorbed without a result.
// The closing edge gives a result: operands load at that edge, then come the iterations
// of the shared radix-2 restoring divider, one multiply, and one output load that waits for m_ready.
// Throughput: edges one per cycle while idle; no new edge is taken until a closing edge's result is loaded.
// Reset (aresetn low, synchronous): phases, captures and result valid cleared, coefs to 1.0.
module pwm_input_capture_measure
    import pimm_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    // capture requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_capture_channel,
    input  logic [CAP_W-1:0]     s_capture_value,
    // measurement results
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_result_channel,
    output logic [TICKS_W-1:0]   m_high_ticks,
    output logic [TICKS_W-1:0]   m_low_ticks,
    output logic [PER_W-1:0]     m_period_ticks,
    output logic [FREQ_W-1:0]    m_frequency_hz,
    output logic [SPEED_W-1:0]   m_speed_value,
    output logic                 m_zero_period
);

    localparam int TW = TIMER_BITS;
    localparam int CW = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
    localparam int PW = TIMER_BITS + 1;

    pimm_state_t state_reg, state_next;

    logic [COEF_W-1:0] coef_reg [2];
    pimm_phase_t       phase_reg [2];
    logic [CW-1:0]     rise_reg [2];
    logic [CW-1:0]     fall_reg [2];

    logic              ch_reg;
    logic [TW-1:0]     high_reg;
    logic [TW-1:0]     low_reg;
    logic [PW-1:0]     period_reg;
    logic              zero_reg;
    logic [PW-1:0]     rem_reg;
    logic [FREQ_W-1:0] quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              m_valid_reg;

    logic              accept;
    logic              start;
    logic              div_run;
    logic              mul_run;
    logic              load_out;
    logic [CW-1:0]     cap;
    logic [TW-1:0]     high_calc;
    logic [TW-1:0]     low_calc;
    logic [PW:0]       trial;
    logic              q_bit;
    logic [FREQ_W-1:0] freq;

    assign cap      = s_capture_value[CW-1:0];
    assign accept   = s_valid && s_ready;
    assign start    = accept && (phase_reg[s_capture_channel] == PH_RISE2);

    // Wrap-corrected differences, modulo the timer width
    assign high_calc = TW'(fall_reg[s_capture_channel]) - TW'(rise_reg[s_capture_channel]);
    assign low_calc  = TW'(cap) - TW'(fall_reg[s_capture_channel]);

    // Restoring divider step: bring down the next dividend bit, try a subtract
    assign trial = {rem_reg, quo_reg[FREQ_W-1]};
    assign q_bit = (trial >= {1'b0, period_reg});

    // Zero period saturates the frequency
    assign freq = zero_reg ? TICK_HZ : quo_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        div_run  = 1'b0;
        mul_run  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_DIV:  div_run  = 1'b1;
            ST_MUL:  mul_run  = 1'b1;
            ST_DONE: load_out = !m_valid_reg || m_ready;
            default: s_ready  = 1'b0;
        endcase
    end

    assign cfg_ready = 1'b1;

    // State and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            coef_reg[0] <= COEF_RST;
            coef_reg[1] <= COEF_RST;
            for (int i = 0; i < 2; i++) begin
                phase_reg[i] <= PH_RISE1;
                rise_reg[i]  <= '0;
                fall_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;

            // result register, freed by the sink
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // coefficient writes; other indexes dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COEF_LEFT:  coef_reg[0] <= cfg_data;
                    REG_COEF_RIGHT: coef_reg[1] <= cfg_data;
                    default: ;
                endcase
            end

            // capture phase sequence; an unused phase code acts as the first rise
            if (accept) begin
                case (phase_reg[s_capture_channel])
                    PH_FALL: begin
                        fall_reg[s_capture_channel]  <= cap;
                        phase_reg[s_capture_channel] <= PH_RISE2;
                    end
                    PH_RISE2: begin
                        phase_reg[s_capture_channel] <= PH_RISE1;
                    end
                    default: begin
                        rise_reg[s_capture_channel]  <= cap;
                        phase_reg[s_capture_channel] <= PH_FALL;
                    end
                endcase
            end
        end
    end

    // Datapath: measurement load, divider iterations, multiply, result load
    always_ff @(posedge aclk) begin
        if (start) begin
            ch_reg     <= s_capture_channel;
            high_reg   <= high_calc;
            low_reg    <= low_calc;
            period_reg <= PW'(high_calc) + PW'(low_calc);
            zero_reg   <= (PW'(high_calc) + PW'(low_calc)) == '0;
            rem_reg    <= '0;
            quo_reg    <= TICK_HZ;
            dcnt_reg   <= '0;
        end
        if (div_run) begin
            rem_reg  <= q_bit ? PW'(trial - {1'b0, period_reg}) : trial[PW-1:0];
            quo_reg  <= {quo_reg[FREQ_W-2:0], q_bit};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (mul_run) begin
            prod_reg <= PROD_W'(freq) * PROD_W'(coef_reg[ch_reg]);
        end
        if (load_out) begin
            m_result_channel <= ch_reg;
            m_high_ticks     <= TICKS_W'(high_reg);
            m_low_ticks      <= TICKS_W'(low_reg);
            m_period_ticks   <= PER_W'(period_reg);
            m_frequency_hz   <= freq;
            m_speed_value    <= SPEED_W'(prod_reg >> Q_FRAC);
            m_zero_period    <= zero_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/pimm_checker.sv =====
`include "pwm_input_capture_measure_defines.svh"

module pimm_checker
    import pimm_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [TICKS_W-1:0] m_high_ticks,
    input logic [TICKS_W-1:0] m_low_ticks,
    input logic [PER_W-1:0]   m_period_ticks,
    input logic [FREQ_W-1:0]  m_frequency_hz,
    input logic               m_zero_period
);

    // A held result keeps its value until taken
    `PIMM_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_period_ticks), "result dropped or changed while stalled")

    // Period is the sum of its halves when the timer fits the fields
    `PIMM_ASSERT(a_period_sum, m_valid && (TIMER_BITS <= TICKS_W) |-> m_period_ticks == PER_W'(m_high_ticks) + PER_W'(m_low_ticks), "period is not high plus low")

    // Zero flag goes with the saturated frequency
    `PIMM_ASSERT(a_zero_sat, m_valid && m_zero_period |-> m_frequency_hz == TICK_HZ && m_period_ticks == '0, "zero period without saturated frequency")

    // Frequency never exceeds the tick rate
    `PIMM_ASSERT(a_freq_range, m_valid |-> m_frequency_hz <= TICK_HZ, "frequency above tick rate")

    // No result straight after reset
    `PIMM_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind pwm_input_capture_measure pimm_checker #(.TIMER_BITS(TIMER_BITS)) u_pimm_checker (.*);
